[rtl/tpi_pkg.sv]
// Package with shared types, constants and codes for the tracked position interpolator.
`default_nettype none
package tpi_pkg;
   localparam int SLOT_COUNT = 1024;
   localparam int KEY_WIDTH = 48;
   localparam int SLOT_SHIFT = 4;
   localparam int SLOT_BITS = $clog2(SLOT_COUNT);

   localparam logic [1:0] REG_JUMP_LIMIT = 2'd0;
   localparam logic [1:0] REG_INIT_PERIOD = 2'd1;
   localparam logic [1:0] REG_MIN_SAMPLE = 2'd2;
   localparam logic [1:0] REG_MAX_SAMPLE = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_PERIOD,
      ST_SQUARE,
      ST_DECIDE,
      ST_WRITE,
      ST_DIVIDE,
      ST_BLEND,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load_input;
      logic eval;
      logic period_step;
      logic square_step;
      logic decide;
      logic write_slot;
      logic div_start;
      logic blend_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic passed;
      logic square_done;
      logic div_done;
      logic blend_done;
   } status_type;
endpackage
`default_nettype wire

[rtl/tracked_position_interpolator_unit.sv]
// Top level of the tracked position interpolator: registers, controller and datapath.
// Sequence: an accepted word reads its slot, is checked and written back; an installed or
// restarted slot then goes straight to the result, else the fraction is formed, by the
// 16-step divider where it needs division, and blended. One word at a time; the next word is
// taken in the cycle after the result is registered, later while an earlier result is stalled.
// Reset: synchronous; a clearing pass empties the slot store before the first word is
// accepted, and the registers return to their defaults.
`default_nettype none
module tracked_position_interpolator_unit import tpi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [KEY_WIDTH-1:0] req_object_key,
   input  wire logic [31:0]          req_now_us,
   input  wire logic signed [31:0]   req_pos_x,
   input  wire logic signed [31:0]   req_pos_y,
   input  wire logic signed [31:0]   req_pos_z,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [31:0]        rsp_smooth_x,
   output logic signed [31:0]        rsp_smooth_y,
   output logic signed [31:0]        rsp_smooth_z,
   output logic                      rsp_passed_raw,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [31:0]          csr_index,
   input  wire logic [31:0]          csr_data
);
   logic [9:0]  jump_ff;
   logic [19:0] init_ff, min_ff, max_ff;
   cmd_type     cmd;
   status_type  status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_ff <= 10'd25;
         init_ff <= 20'd50000;
         min_ff <= 20'd8000;
         max_ff <= 20'd250000;
      end else if (csr_valid && csr_index[31:2] == 30'd0) begin
         case (csr_index[1:0])
            REG_JUMP_LIMIT: jump_ff <= csr_data[9:0];
            REG_INIT_PERIOD: init_ff <= csr_data[19:0];
            REG_MIN_SAMPLE: min_ff <= csr_data[19:0];
            REG_MAX_SAMPLE: max_ff <= csr_data[19:0];
            default: jump_ff <= jump_ff;
         endcase
      end
   end

   tpi_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .cmd(cmd)
   );

   tpi_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .jump_limit_sq(jump_ff), .initial_period(init_ff),
      .min_period_sample(min_ff), .max_period_sample(max_ff),
      .req_object_key(req_object_key), .req_now_us(req_now_us),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_smooth_x(rsp_smooth_x), .rsp_smooth_y(rsp_smooth_y),
      .rsp_smooth_z(rsp_smooth_z), .rsp_passed_raw(rsp_passed_raw)
   );
endmodule
`default_nettype wire

[rtl/tpi_datapath.sv]
// Datapath of the tracked position interpolator: slot memories, jump test and blend.
`default_nettype none
module tpi_datapath import tpi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  wire logic [9:0]           jump_limit_sq,
   input  wire logic [19:0]          initial_period,
   input  wire logic [19:0]          min_period_sample,
   input  wire logic [19:0]          max_period_sample,
   input  wire logic [KEY_WIDTH-1:0] req_object_key,
   input  wire logic [31:0]          req_now_us,
   input  wire logic signed [31:0]   req_pos_x,
   input  wire logic signed [31:0]   req_pos_y,
   input  wire logic signed [31:0]   req_pos_z,
   output logic signed [31:0]        rsp_smooth_x,
   output logic signed [31:0]        rsp_smooth_y,
   output logic signed [31:0]        rsp_smooth_z,
   output logic                      rsp_passed_raw
);
   localparam int ENTRY_W = 1 + KEY_WIDTH + 6 * 32 + 32 + 20;

   logic [ENTRY_W-1:0]   mem [SLOT_COUNT];
   logic [ENTRY_W-1:0]   rd_ff;
   logic [SLOT_BITS-1:0] clr_ff;
   logic                 clr_done_ff;
   logic [SLOT_BITS-1:0] slot_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [31:0]          now_ff;
   logic signed [31:0]   raw_ff [3];
   logic signed [31:0]   prev_ff [3];
   logic signed [31:0]   curr_ff [3];
   logic [31:0]          time_ff;
   logic [19:0]          period_ff;
   logic                 passed_ff;
   logic                 changed_ff;
   logic                 adapt_ff;
   logic [31:0]          dt_ff;
   logic [1:0]           sq_cnt_ff;
   logic [65:0]          d2_ff;
   logic [26:0]          pacc_ff;
   logic [16:0]          frac_ff;
   logic [47:0]          rem_ff;
   logic [14:0]          quo_ff;
   logic [4:0]           div_cnt_ff;
   logic                 div_busy_ff;
   logic                 div_done_ff;
   logic [1:0]           bl_cnt_ff;
   logic                 bl_done_ff;
   logic signed [31:0]   res_ff [3];

   logic                 rd_valid;
   logic [KEY_WIDTH-1:0] rd_tag;
   logic signed [31:0]   rd_prev [3];
   logic signed [31:0]   rd_curr [3];
   logic [31:0]          rd_time;
   logic [19:0]          rd_period;
   logic signed [32:0]   sq_diff;
   logic [31:0]          sq_mag;
   logic [63:0]          sq_prod;
   logic [58:0]          pdiv_prod;
   logic [31:0]          elapsed;
   logic [48:0]          div_trial;
   logic signed [32:0]   bl_diff;
   logic signed [50:0]   bl_prod;
   logic signed [50:0]   bl_sum;
   logic [ENTRY_W-1:0]   wr_data;

   assign {rd_valid, rd_tag, rd_prev[0], rd_prev[1], rd_prev[2],
           rd_curr[0], rd_curr[1], rd_curr[2], rd_time, rd_period} = rd_ff;
   assign wr_data = {1'b1, key_ff, prev_ff[0], prev_ff[1], prev_ff[2],
                     curr_ff[0], curr_ff[1], curr_ff[2], time_ff, period_ff};

   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem[clr_ff] <= '0;
      else if (cmd.write_slot) mem[slot_ff] <= wr_data;
      rd_ff <= mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
         clr_done_ff <= (clr_ff == SLOT_BITS'(SLOT_COUNT - 1));
      end
   end

   assign sq_diff = 33'(raw_ff[sq_cnt_ff]) - 33'(curr_ff[sq_cnt_ff]);
   assign sq_mag = sq_diff[32] ? 32'(-sq_diff) : sq_diff[31:0];
   assign sq_prod = 64'(sq_mag) * 64'(sq_mag);
   assign pdiv_prod = 59'(pacc_ff) * 59'(32'hCCCCCCCD);
   assign elapsed = now_ff - time_ff;
   assign div_trial = {rem_ff, 1'b0} - {29'd0, period_ff};
   assign bl_diff = 33'(curr_ff[bl_cnt_ff]) - 33'(prev_ff[bl_cnt_ff]);
   assign bl_prod = 51'(bl_diff) * $signed({34'd0, frac_ff});
   assign bl_sum = bl_prod + 51'sd32768;

   always_ff @(posedge clock) begin
      if (cmd.load_input) begin
         slot_ff <= req_object_key[SLOT_SHIFT +: SLOT_BITS];
         key_ff <= req_object_key;
         now_ff <= req_now_us;
         raw_ff[0] <= req_pos_x;
         raw_ff[1] <= req_pos_y;
         raw_ff[2] <= req_pos_z;
      end
      if (cmd.eval) begin
         dt_ff <= now_ff - rd_time;
         changed_ff <= (raw_ff[0] != rd_curr[0]) || (raw_ff[1] != rd_curr[1])
                       || (raw_ff[2] != rd_curr[2]);
         sq_cnt_ff <= '0;
         d2_ff <= '0;
         if (!rd_valid || rd_tag != key_ff) begin
            passed_ff <= 1'b1;
            prev_ff <= raw_ff;
            curr_ff <= raw_ff;
            time_ff <= now_ff;
            period_ff <= initial_period;
         end else begin
            passed_ff <= 1'b0;
            prev_ff <= rd_prev;
            curr_ff <= rd_curr;
            time_ff <= rd_time;
            period_ff <= rd_period;
         end
      end
      if (cmd.period_step) begin
         adapt_ff <= !dt_ff[31] && (dt_ff[30:0] > 31'(min_period_sample))
                     && (dt_ff[30:0] < 31'(max_period_sample));
         pacc_ff <= 27'(7 * period_ff) + 27'(3 * dt_ff[19:0]) + 27'd5;
      end
      if (cmd.square_step) begin
         d2_ff <= d2_ff + 66'(sq_prod);
         sq_cnt_ff <= sq_cnt_ff + 1'b1;
      end
      if (cmd.decide && !passed_ff && changed_ff) begin
         if (d2_ff > {24'd0, jump_limit_sq, 32'd0} || dt_ff[31] || dt_ff == 32'd0) begin
            passed_ff <= 1'b1;
            prev_ff <= raw_ff;
            curr_ff <= raw_ff;
         end else begin
            prev_ff <= curr_ff;
            curr_ff <= raw_ff;
            if (adapt_ff) period_ff <= pdiv_prod[54:35];
         end
         time_ff <= now_ff;
      end
      if (cmd.blend_step) begin
         res_ff[bl_cnt_ff] <= 32'(prev_ff[bl_cnt_ff] + 32'(bl_sum >>> 16));
      end
      if (cmd.out_load) begin
         rsp_smooth_x <= passed_ff ? raw_ff[0] : res_ff[0];
         rsp_smooth_y <= passed_ff ? raw_ff[1] : res_ff[1];
         rsp_smooth_z <= passed_ff ? raw_ff[2] : res_ff[2];
         rsp_passed_raw <= passed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
         bl_cnt_ff <= '0;
         bl_done_ff <= 1'b0;
      end else begin
         div_done_ff <= 1'b0;
         bl_done_ff <= 1'b0;
         if (cmd.div_start) begin
            bl_cnt_ff <= '0;
            if (elapsed[31] || elapsed == 32'd0) begin
               frac_ff <= '0;
               div_done_ff <= 1'b1;
            end else if (period_ff == 20'd0 || elapsed[30:0] >= 31'(period_ff)) begin
               frac_ff <= 17'd65536;
               div_done_ff <= 1'b1;
            end else begin
               rem_ff <= 48'(elapsed[19:0]);
               quo_ff <= '0;
               div_cnt_ff <= '0;
               div_busy_ff <= 1'b1;
            end
         end else if (div_busy_ff) begin
            if (!div_trial[48]) rem_ff <= div_trial[47:0];
            else rem_ff <= {rem_ff[46:0], 1'b0};
            quo_ff <= {quo_ff[13:0], !div_trial[48]};
            div_cnt_ff <= div_cnt_ff + 1'b1;
            if (div_cnt_ff == 5'd15) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
               frac_ff <= {1'b0, quo_ff, !div_trial[48]};
            end
         end
         if (cmd.blend_step) begin
            bl_cnt_ff <= bl_cnt_ff + 1'b1;
            bl_done_ff <= (bl_cnt_ff == 2'd2);
         end
      end
   end

   assign status.clear_done = clr_done_ff;
   assign status.passed = passed_ff;
   assign status.square_done = (sq_cnt_ff == 2'd3);
   assign status.div_done = div_done_ff;
   assign status.blend_done = bl_done_ff;

   property p_passed_raw_out;
      @(posedge clock) disable iff (reset) cmd.out_load && passed_ff |=>
         rsp_smooth_x == $past(raw_ff[0]);
   endproperty
   a_passed_raw_out: assert property (p_passed_raw_out) else $error("raw not passed");

   property p_no_double_cmd;
      @(posedge clock) disable iff (reset) !(cmd.clear_step && cmd.write_slot);
   endproperty
   a_no_double_cmd: assert property (p_no_double_cmd) else $error("clear and write");

   property p_div_one_busy;
      @(posedge clock) disable iff (reset) cmd.div_start |-> !div_busy_ff;
   endproperty
   a_div_one_busy: assert property (p_div_one_busy) else $error("divider restarted");
endmodule
`default_nettype wire

[rtl/tpi_controller.sv]
// Controller state machine of the tracked position interpolator.
`default_nettype none
module tpi_controller import tpi_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   input  status_type status,
   output cmd_type   cmd
);
   state_type state_ff, state_in;
   logic      out_full_ff, out_full_in;
   logic      frac_wait_ff, frac_wait_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         out_full_ff <= 1'b0;
         frac_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_full_ff <= out_full_in;
         frac_wait_ff <= frac_wait_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_full_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      out_full_in = out_full_ff && rsp_stall;
      frac_wait_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_input = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_PERIOD;
         end
         ST_PERIOD: begin
            cmd.period_step = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (status.square_done) state_in = ST_DECIDE;
            else cmd.square_step = 1'b1;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write_slot = 1'b1;
            if (status.passed) state_in = ST_OUTPUT;
            else begin
               cmd.div_start = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (frac_wait_ff) begin
               cmd.blend_step = 1'b1;
               state_in = ST_BLEND;
            end else if (status.div_done) frac_wait_in = 1'b1;
         end
         ST_BLEND: begin
            if (status.blend_done) state_in = ST_OUTPUT;
            else cmd.blend_step = 1'b1;
         end
         ST_OUTPUT: begin
            if (!out_full_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               out_full_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   property p_out_hold;
      @(posedge clock) disable iff (reset) rsp_valid && rsp_stall |=> rsp_valid;
   endproperty
   a_out_hold: assert property (p_out_hold) else $error("result dropped");

   property p_accept_only_idle;
      @(posedge clock) disable iff (reset) cmd.load_input |-> state_ff == ST_IDLE;
   endproperty
   a_accept_only_idle: assert property (p_accept_only_idle) else $error("bad accept");

   property p_no_write_in_clear;
      @(posedge clock) disable iff (reset) state_ff == ST_CLEAR |-> !cmd.write_slot;
   endproperty
   a_no_write_in_clear: assert property (p_no_write_in_clear) else $error("write in clear");
endmodule
`default_nettype wire
